FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/rits_pkg.sv
// types and constants of the rigid transform inlier scorer
// no dependencies; imported by every other file of the block but assert_macros.svh
package rits_pkg;

   localparam int COORD_W = 24;
   localparam int ROT_W   = 18;
   localparam int ROW_W   = 54;
   localparam int DIST_W  = 40;
   localparam int CNT_OUT_W = 12;
   localparam int TALLY_W = 13;
   localparam int ERR_W   = 52;
   localparam int DIV_STEPS = 52;
   localparam int CSR_IDX_W = 3;

   localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
   localparam logic [ERR_W-1:0]   ERR_MAX   = '1;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH   = 3'd6;

   localparam logic [ROW_W-1:0]  ROT_ROW0_RST = 54'd65536;
   localparam logic [ROW_W-1:0]  ROT_ROW1_RST = 54'd4294967296;
   localparam logic [ROW_W-1:0]  ROT_ROW2_RST = 54'd17592186044416;
   localparam logic [DIST_W-1:0] THRESH_RST   = 40'd65536;

   typedef struct packed {
      logic signed [COORD_W-1:0] source_x;
      logic signed [COORD_W-1:0] source_y;
      logic signed [COORD_W-1:0] source_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
      logic                      last_pair;
   } rits_req_type;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] pair_index;
      logic                 is_inlier;
      logic [DIST_W-1:0]    squared_distance;
      logic                 pass_done;
      logic [TALLY_W-1:0]   inlier_count;
      logic [DIST_W-1:0]    mean_sq_error;
      logic                 no_inliers;
   } rits_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_FIN,
      ST_UPD,
      ST_DIV,
      ST_LOAD
   } rits_state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic       square;
      logic [1:0] axis;
      logic [1:0] col;
      logic       finish;
      logic       update;
      logic       div_step;
      logic       load_out;
   } rits_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic out_full;
   } rits_status_type;

endpackage

FILE: rtl/core/rits_channels.sv
// handshake channel interfaces of the inlier scorer
// depends on rits_pkg for the payload types
interface rits_req_if
   import rits_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rits_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rits_rsp_if
   import rits_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rits_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rits_csr_if
   import rits_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ROW_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rigid_transform_inlier_scorer.sv
// flow: a request is captured, then the single shared multiplier forms nine
// rotation products and three squares in turn; on the closing pair of a pass with
// inliers a one-bit-per-cycle divider forms the mean. One pair is in flight at a
// time: a new pair is taken only after the previous result enters the output register
// reset: synchronous, clears control, pass sums and restores config defaults
module rigid_transform_inlier_scorer
   import rits_pkg::*;
#(
   parameter int MAX_PAIRS       = 4096,
   parameter int COORD_FRAC_BITS = 16
)
(
   input  logic clock,
   input  logic reset,
   rits_req_if.sink   req_chan,
   rits_rsp_if.source rsp_chan,
   rits_csr_if.sink   csr_chan
);

   rits_cmd_type    cmd;
   rits_status_type status;

   // config writes are always taken
   assign csr_chan.ready = 1'b1;

   rits_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rits_datapath #(
      .MAX_PAIRS       (MAX_PAIRS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .csr_valid   (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

FILE: rtl/core/rits_ctrl.sv
// sequencer of the inlier scorer: steps the shared multiplier and the divider
// depends on rits_pkg
module rits_ctrl
   import rits_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rits_status_type status,
   output rits_cmd_type    cmd
);

   rits_state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] col_ff, col_in;
   logic       sq_ff, sq_in;
   logic [5:0] div_cnt_ff, div_cnt_in;

   // state and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         axis_ff    <= '0;
         col_ff     <= '0;
         sq_ff      <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         axis_ff    <= axis_in;
         col_ff     <= col_in;
         sq_ff      <= sq_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      col_in     = col_ff;
      sq_in      = sq_ff;
      div_cnt_in = div_cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.axis   = axis_ff;
      cmd.col    = col_ff;
      cmd.square = sq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               axis_in     = '0;
               col_in      = '0;
               sq_in       = 1'b0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (sq_ff) begin
               // squares: one per axis
               if (axis_ff == 2'd2) begin
                  state_in = ST_DRAIN;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else if (col_ff == 2'd2) begin
               col_in = '0;
               if (axis_ff == 2'd2) begin
                  axis_in = '0;
                  sq_in   = 1'b1;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            div_cnt_in = '0;
            state_in   = status.need_div ? ST_DIV : ST_LOAD;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!status.out_full) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/rits_datapath.sv
// datapath of the inlier scorer: config registers, shared multiplier,
// residual and distance logic, pass sums, bit-serial divider, output register
// depends on rits_pkg
module rits_datapath
   import rits_pkg::*;
#(
   parameter int MAX_PAIRS       = 4096,
   parameter int COORD_FRAC_BITS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  rits_cmd_type         cmd,
   output rits_status_type      status,
   input  rits_req_type         req_payload,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rits_rsp_type         rsp_payload
);

   localparam int CNT_W = $clog2(MAX_PAIRS);
   localparam int ACC_W = 45;
   localparam int RES_W = 48;
   localparam int SQ_W  = 66;
   localparam int RND_W = 65 - COORD_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COORD_FRAC_BITS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_PAIRS - 1);

   // configuration registers
   logic [ROW_W-1:0]          rot_ff [3];
   logic signed [COORD_W-1:0] shift_ff [3];
   logic [DIST_W-1:0]         thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= ROT_ROW0_RST;
         rot_ff[1]   <= ROT_ROW1_RST;
         rot_ff[2]   <= ROT_ROW2_RST;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
         thr_ff      <= THRESH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROT_ROW0: rot_ff[0]   <= csr_data;
            CSR_ROT_ROW1: rot_ff[1]   <= csr_data;
            CSR_ROT_ROW2: rot_ff[2]   <= csr_data;
            CSR_SHIFT_X:  shift_ff[0] <= csr_data[COORD_W-1:0];
            CSR_SHIFT_Y:  shift_ff[1] <= csr_data[COORD_W-1:0];
            CSR_SHIFT_Z:  shift_ff[2] <= csr_data[COORD_W-1:0];
            CSR_THRESH:   thr_ff      <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // captured transaction
   logic signed [COORD_W-1:0] src_ff [3];
   logic signed [COORD_W-1:0] tgt_ff [3];
   logic                      last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff[0] <= req_payload.source_x;
         src_ff[1] <= req_payload.source_y;
         src_ff[2] <= req_payload.source_z;
         tgt_ff[0] <= req_payload.target_x;
         tgt_ff[1] <= req_payload.target_y;
         tgt_ff[2] <= req_payload.target_z;
         last_ff   <= req_payload.last_pair;
      end
   end

   // shared multiplier: rotation products, then squares of residual magnitudes
   logic [31:0]           mag_ff [3];
   logic signed [ROT_W-1:0] rot_entry;
   logic signed [32:0]    mul_a, mul_b;
   logic signed [SQ_W-1:0] prod_in;
   logic signed [SQ_W-1:0] prod_ff;
   logic                  pv_ff, psq_ff;
   logic [1:0]            paxis_ff, pcol_ff;

   always_comb begin
      rot_entry = rot_ff[cmd.axis][ROT_W*cmd.col +: ROT_W];
      if (cmd.square) begin
         mul_a = signed'({1'b0, mag_ff[cmd.axis]});
         mul_b = mul_a;
      end else begin
         mul_a = 33'(rot_entry);
         mul_b = 33'(src_ff[cmd.col]);
      end
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      psq_ff   <= cmd.square;
      paxis_ff <= cmd.axis;
      pcol_ff  <= cmd.col;
   end

   // accumulate products into residuals and the sum of squares
   logic signed [ACC_W-1:0] rot_acc_ff;
   logic signed [ACC_W-1:0] row_sum;
   logic signed [ACC_W-1:0] row_round;
   logic signed [RES_W-1:0] resid;
   logic [RES_W-1:0]        mag;
   logic [SQ_W-1:0]         sumsq_ff;
   logic                    sat_ff;

   always_comb begin
      row_sum   = rot_acc_ff + ACC_W'(prod_ff) + ROUND_HALF;
      row_round = row_sum >>> COORD_FRAC_BITS;
      resid     = RES_W'(row_round) + RES_W'(shift_ff[paxis_ff]) - RES_W'(tgt_ff[paxis_ff]);
      mag       = resid[RES_W-1] ? unsigned'(-resid) : unsigned'(resid);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sat_ff <= 1'b0;
      end else if (pv_ff && !psq_ff) begin
         if (pcol_ff == 2'd0) begin
            rot_acc_ff <= ACC_W'(prod_ff);
         end else if (pcol_ff == 2'd1) begin
            rot_acc_ff <= rot_acc_ff + ACC_W'(prod_ff);
         end else begin
            mag_ff[paxis_ff] <= mag[31:0];
            if (|mag[RES_W-1:32]) begin
               sat_ff <= 1'b1;
            end
         end
      end else if (pv_ff && psq_ff) begin
         if (paxis_ff == 2'd0) begin
            sumsq_ff <= unsigned'(prod_ff);
         end else begin
            sumsq_ff <= sumsq_ff + unsigned'(prod_ff);
         end
      end
   end

   // round and saturate the squared distance
   logic [RND_W-1:0]  rnd;
   logic [DIST_W-1:0] dist_ff;

   always_comb begin
      rnd = RND_W'(sumsq_ff[63:COORD_FRAC_BITS]) + RND_W'(sumsq_ff[COORD_FRAC_BITS-1]);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (sat_ff || (|sumsq_ff[SQ_W-1:64]) || (rnd > RND_W'(DIST_MAX))) begin
            dist_ff <= DIST_MAX;
         end else begin
            dist_ff <= rnd[DIST_W-1:0];
         end
      end
   end

   // pass sums and staged result fields
   logic [CNT_W-1:0]   cnt_ff;
   logic [TALLY_W-1:0] tally_ff;
   logic [ERR_W-1:0]   err_ff;
   logic               inlier;
   logic               done;
   logic [TALLY_W-1:0] tally_next;
   logic [ERR_W:0]     err_add;
   logic [ERR_W-1:0]   err_next;
   logic [31:0]        cnt_wide;

   always_comb begin
      inlier     = dist_ff < thr_ff;
      done       = last_ff || (cnt_ff == LAST_CNT);
      tally_next = (inlier && tally_ff != TALLY_MAX) ? tally_ff + 1'b1 : tally_ff;
      err_add    = (ERR_W+1)'(err_ff) + (ERR_W+1)'(dist_ff);
      if (!inlier) begin
         err_next = err_ff;
      end else if (err_add[ERR_W]) begin
         err_next = ERR_MAX;
      end else begin
         err_next = err_add[ERR_W-1:0];
      end
      cnt_wide = 32'(cnt_ff);
   end

   assign status.need_div = done && (tally_next != '0);

   rits_rsp_type res_ff;
   logic         use_div_ff;

   // bit-serial restoring divider state
   logic [TALLY_W-1:0] divisor_ff;
   logic [TALLY_W-1:0] rem_ff;
   logic [ERR_W-1:0]   quo_ff;
   logic [TALLY_W:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         tally_ff <= '0;
         err_ff   <= '0;
      end else if (cmd.update) begin
         if (done) begin
            cnt_ff   <= '0;
            tally_ff <= '0;
            err_ff   <= '0;
         end else begin
            cnt_ff   <= cnt_ff + 1'b1;
            tally_ff <= tally_next;
            err_ff   <= err_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_ff.pair_index       <= cnt_wide[CNT_OUT_W-1:0];
         res_ff.is_inlier        <= inlier;
         res_ff.squared_distance <= dist_ff;
         res_ff.pass_done        <= done;
         res_ff.inlier_count     <= done ? tally_next : '0;
         res_ff.no_inliers       <= done && (tally_next == '0);
         res_ff.mean_sq_error    <= (done && tally_next == '0) ? DIST_MAX : '0;
         use_div_ff              <= done && (tally_next != '0);
         divisor_ff              <= tally_next;
         rem_ff                  <= '0;
         quo_ff                  <= err_next;
      end else if (cmd.div_step) begin
         if (!trial[TALLY_W]) begin
            rem_ff <= trial[TALLY_W-1:0];
         end else begin
            rem_ff <= {rem_ff[TALLY_W-2:0], quo_ff[ERR_W-1]};
         end
         quo_ff <= {quo_ff[ERR_W-2:0], ~trial[TALLY_W]};
      end
   end

   assign trial = {rem_ff, quo_ff[ERR_W-1]} - {1'b0, divisor_ff};

   // output register
   logic         rsp_valid_ff;
   rits_rsp_type rsp_ff;
   rits_rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // staged fields with the saturated quotient as mean
   always_comb begin
      rsp_in = res_ff;
      if (use_div_ff) begin
         rsp_in.mean_sq_error = (|quo_ff[ERR_W-1:DIST_W]) ? DIST_MAX : quo_ff[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_full = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

FILE: rtl/core/rits_checker.sv
// port-level checks of the inlier scorer, bound to the top level
// depends on rits_pkg and assert_macros.svh
`include "assert_macros.svh"

module rits_checker
   import rits_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rits_rsp_type rsp_payload
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // a stalled response stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one transaction in flight: ready drops right after an accept
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // summary fields are zero outside a pass end
   `ASSERT_SAME(a_summary_zero, clock, reset, rsp_fire && !rsp_payload.pass_done,
      rsp_payload.inlier_count == '0 && rsp_payload.mean_sq_error == '0 && !rsp_payload.no_inliers)

   // an empty pass reports an infinite mean
   `ASSERT_SAME(a_no_inliers, clock, reset, rsp_fire && rsp_payload.no_inliers,
      rsp_payload.pass_done && rsp_payload.inlier_count == '0 && rsp_payload.mean_sq_error == DIST_MAX)

endmodule

bind rigid_transform_inlier_scorer rits_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

FILE: sim/rigid_transform_inlier_scorer_tb.sv
// testbench of the rigid transform inlier scorer: directed and random point pairs
// depends on rits_pkg, the rits channel interfaces and the scorer rtl
`timescale 1ns / 1ps

module rigid_transform_inlier_scorer_tb;
   import rits_pkg::*;

   localparam int                   STALL_LIMIT = 20000;
   localparam int                   SETTLE_CYCLES = 100;
   localparam int                   PASS_LENGTH_MAX = 4096;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0]          DIST_SAT = 64'hFF_FFFF_FFFF;

   // scoreboard: transform and distance predictor plus expected result queue
   class pair_scorer;
      logic [ROW_W-1:0]   rot_row[3];
      logic [COORD_W-1:0] shift[3];
      logic [DIST_W-1:0]  threshold;
      int unsigned        pair_count;
      int unsigned        tally;
      logic [63:0]        err_sum;
      rits_rsp_type       expected_results[$];
      int                 mismatches;

      function new();
         rot_row[0] = ROT_ROW0_RST;
         rot_row[1] = ROT_ROW1_RST;
         rot_row[2] = ROT_ROW2_RST;
         shift[0] = '0;
         shift[1] = '0;
         shift[2] = '0;
         threshold = THRESH_RST;
         pair_count = 0;
         tally = 0;
         err_sum = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
         case (idx)
            CSR_ROT_ROW0: rot_row[0] = data;
            CSR_ROT_ROW1: rot_row[1] = data;
            CSR_ROT_ROW2: rot_row[2] = data;
            CSR_SHIFT_X: shift[0] = data[COORD_W-1:0];
            CSR_SHIFT_Y: shift[1] = data[COORD_W-1:0];
            CSR_SHIFT_Z: shift[2] = data[COORD_W-1:0];
            CSR_THRESH: threshold = data[DIST_W-1:0];
            default: ;
         endcase
      endfunction

      // rotate, round half up, then add shift and subtract target
      function longint axis_residual(int axis, longint sx, longint sy, longint sz,
                                     logic [COORD_W-1:0] tgt);
         longint acc;
         acc = longint'($signed(rot_row[axis][17:0])) * sx
             + longint'($signed(rot_row[axis][35:18])) * sy
             + longint'($signed(rot_row[axis][53:36])) * sz;
         acc = (acc + 64'sd32768) >>> 16;
         return acc + longint'($signed(shift[axis])) - longint'($signed(tgt));
      endfunction

      function void note_pair(rits_req_type p);
         longint       d[3];
         logic [63:0]  mag, sq, sum, dist_val;
         bit           sat;
         bit           done;
         rits_rsp_type r;
         d[0] = axis_residual(0, p.source_x, p.source_y, p.source_z, p.target_x);
         d[1] = axis_residual(1, p.source_x, p.source_y, p.source_z, p.target_y);
         d[2] = axis_residual(2, p.source_x, p.source_y, p.source_z, p.target_z);
         sum = '0;
         sat = 0;
         for (int i = 0; i < 3; i++) begin
            mag = d[i] < 0 ? -d[i] : d[i];
            if (mag > 64'hFFFF_FFFF) sat = 1;
            sq = mag * mag;
            if (!sat && sum > ~sq) sat = 1;
            if (!sat) sum = sum + sq;
         end
         if (sat) begin
            dist_val = DIST_SAT;
         end else begin
            dist_val = (sum >> 16) + 64'(sum[15]);
            if (dist_val > DIST_SAT) dist_val = DIST_SAT;
         end
         r = '0;
         r.pair_index = pair_count[CNT_OUT_W-1:0];
         r.squared_distance = dist_val[DIST_W-1:0];
         r.is_inlier = dist_val < 64'(threshold);
         if (r.is_inlier) begin
            if (tally < 8191) tally++;
            err_sum = err_sum + dist_val;
            if (err_sum > 64'hF_FFFF_FFFF_FFFF) err_sum = 64'hF_FFFF_FFFF_FFFF;
         end
         done = p.last_pair || pair_count >= PASS_LENGTH_MAX - 1;
         r.pass_done = done;
         if (done) begin
            r.inlier_count = tally[TALLY_W-1:0];
            if (tally == 0) begin
               r.mean_sq_error = DIST_MAX;
               r.no_inliers = 1'b1;
            end else begin
               sum = err_sum / 64'(tally);
               r.mean_sq_error = sum > DIST_SAT ? DIST_MAX : sum[DIST_W-1:0];
            end
            pair_count = 0;
            tally = 0;
            err_sum = '0;
         end else begin
            pair_count++;
         end
         expected_results = {expected_results, r};
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h expected %0h", field, got, want);
         mismatches++;
      endtask

      task check_result(rits_rsp_type got);
         rits_rsp_type want;
         if (expected_results.size() == 0) begin
            report("unexpected transaction", 64'(got.pair_index), 64'(0));
         end else begin
            want = expected_results.pop_front();
            if (got.pair_index !== want.pair_index)
               report("pair_index", 64'(got.pair_index), 64'(want.pair_index));
            if (got.is_inlier !== want.is_inlier)
               report("is_inlier", 64'(got.is_inlier), 64'(want.is_inlier));
            if (got.squared_distance !== want.squared_distance)
               report("squared_distance", 64'(got.squared_distance),
                      64'(want.squared_distance));
            if (got.pass_done !== want.pass_done)
               report("pass_done", 64'(got.pass_done), 64'(want.pass_done));
            if (got.inlier_count !== want.inlier_count)
               report("inlier_count", 64'(got.inlier_count), 64'(want.inlier_count));
            if (got.mean_sq_error !== want.mean_sq_error)
               report("mean_sq_error", 64'(got.mean_sq_error), 64'(want.mean_sq_error));
            if (got.no_inliers !== want.no_inliers)
               report("no_inliers", 64'(got.no_inliers), 64'(want.no_inliers));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   bit         idling = 1'b1;
   int         quiet_cycles = 0;
   pair_scorer scorer = new();

   rits_req_if req_if ();
   rits_rsp_if rsp_if ();
   rits_csr_if csr_if ();

   rigid_transform_inlier_scorer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
   end

   // result side: random back-pressure, checked at the rising edge
   always @(negedge clock) begin
      rsp_if.ready <= !idling || ($urandom_range(99, 0) >= 10);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) scorer.check_result(rsp_if.payload);
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task send_pair(rits_req_type p);
      @(negedge clock);
      while (idling && $urandom_range(99, 0) < 10) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      scorer.note_pair(p);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
      @(negedge clock);
      req_if.valid <= 1'b0;
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      scorer.write_reg(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // let every outstanding result arrive, then let the block settle
   task drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (scorer.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic rits_req_type coords(int sx, int sy, int sz, int tx, int ty, int tz,
                                           bit last);
      rits_req_type p;
      p.source_x = COORD_W'(sx);
      p.source_y = COORD_W'(sy);
      p.source_z = COORD_W'(sz);
      p.target_x = COORD_W'(tx);
      p.target_y = COORD_W'(ty);
      p.target_z = COORD_W'(tz);
      p.last_pair = last;
      return p;
   endfunction

   // wide random points or points whose target sits near the source
   function automatic rits_req_type random_pair(bit last);
      rits_req_type p;
      int           sx, sy, sz;
      if ($urandom_range(3, 0) == 0) begin
         p = coords($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
      end else begin
         sx = $urandom_range(2 ** 21, 0) - 2 ** 20;
         sy = $urandom_range(2 ** 21, 0) - 2 ** 20;
         sz = $urandom_range(2 ** 21, 0) - 2 ** 20;
         p = coords(sx, sy, sz, sx + $urandom_range(8192, 0) - 4096,
                    sy + $urandom_range(8192, 0) - 4096,
                    sz + $urandom_range(8192, 0) - 4096, last);
      end
      return p;
   endfunction

   function automatic logic [ROW_W-1:0] random_row(int axis);
      logic [ROW_W-1:0] row;
      if ($urandom_range(1, 0) == 0) begin
         row = ROW_W'({$urandom, $urandom});
      end else begin
         row = '0;
         row[18 * axis +: 18] = 18'(65536 + $urandom_range(512, 0) - 256);
         row[18 * ((axis + 1) % 3) +: 18] = 18'($urandom_range(1024, 0) - 512);
      end
      return row;
   endfunction

   task random_config();
      logic [DIST_W-1:0] thr;
      write_csr(CSR_ROT_ROW0, random_row(0));
      write_csr(CSR_ROT_ROW1, random_row(1));
      write_csr(CSR_ROT_ROW2, random_row(2));
      write_csr(CSR_SHIFT_X,
                ROW_W'($urandom_range(1, 0) ? $urandom : $urandom_range(4096, 0)));
      write_csr(CSR_SHIFT_Y,
                ROW_W'($urandom_range(1, 0) ? $urandom : $urandom_range(4096, 0)));
      write_csr(CSR_SHIFT_Z,
                ROW_W'($urandom_range(1, 0) ? $urandom : $urandom_range(4096, 0)));
      thr = $urandom_range(1, 0) ? DIST_W'({$urandom, $urandom})
                                 : DIST_W'($urandom_range(2 ** 20, 0));
      write_csr(CSR_THRESH, ROW_W'(thr));
   endtask

   task random_passes(int count);
      int left, pass_left;
      left = count;
      while (left > 0) begin
         pass_left = $urandom_range(30, 1);
         while (pass_left > 0 && left > 0) begin
            send_pair(random_pair(pass_left == 1 || left == 1));
            pass_left--;
            left--;
         end
      end
   endtask

   initial begin
      localparam int CMAX = 8388607;
      localparam int CMIN = -8388608;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset: zero, extremes, inlier and no-inlier passes
      send_pair(coords(0, 0, 0, 0, 0, 0, 1'b1));
      send_pair(coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0));
      send_pair(coords(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1));
      send_pair(coords(65536, 262144, 8388607, 65536, 65536, 32768, 1'b0));
      send_pair(coords(100, 0, 0, 0, 0, 0, 1'b1));
      send_pair(coords(CMAX, 0, 0, CMAX, 0, 0, 1'b1));
      drain();

      // rotation entries at their negative extreme, lowest shifts, widest threshold
      write_csr(CSR_ROT_ROW0, {3{18'h20000}});
      write_csr(CSR_ROT_ROW1, {3{18'h20000}});
      write_csr(CSR_ROT_ROW2, {3{18'h20000}});
      write_csr(CSR_SHIFT_X, 54'hFF_FF80_0000);
      write_csr(CSR_SHIFT_Y, 54'h80_0000);
      write_csr(CSR_SHIFT_Z, 54'h80_0000);
      write_csr(CSR_THRESH, {ROW_W{1'b1}});
      write_csr(CSR_UNUSED, 54'h0);
      send_pair(coords(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0));
      send_pair(coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0));
      send_pair(coords(1, -1, 1, 0, 0, 0, 1'b0));
      send_pair(coords(-32768, 0, 0, 0, 0, 0, 1'b1));
      drain();

      // positive extremes, zero threshold so nothing is an inlier
      write_csr(CSR_ROT_ROW0, {3{18'h1FFFF}});
      write_csr(CSR_ROT_ROW1, {3{18'h1FFFF}});
      write_csr(CSR_ROT_ROW2, {3{18'h1FFFF}});
      write_csr(CSR_SHIFT_X, 54'h7F_FFFF);
      write_csr(CSR_SHIFT_Y, 54'h7F_FFFF);
      write_csr(CSR_SHIFT_Z, 54'h7F_FFFF);
      write_csr(CSR_THRESH, 54'h0);
      send_pair(coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0));
      send_pair(coords(0, 0, 0, CMAX, CMAX, CMAX, 1'b0));
      send_pair(coords(CMIN, CMAX, CMIN, 0, 0, 0, 1'b1));
      drain();

      // random settings, one of them with no idling on either side
      for (int ph = 0; ph < 8; ph++) begin
         idling = (ph != 3);
         random_config();
         random_passes(85);
         drain();
      end
      idling = 1'b1;

      if (scorer.mismatches == 0 && scorer.expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
